>>> sv/a2bc_pkg.sv
// Shared types, constants and index functions for the Argon2 block compression unit.
`timescale 1ns / 1ps

package a2bc_pkg;

	localparam int OWORDS_PER_BLOCK = 64;
	localparam int WORDS_PER_BLOCK  = 2 * OWORDS_PER_BLOCK;
	localparam int OW_W             = $clog2(OWORDS_PER_BLOCK);
	localparam int WA_W             = $clog2(WORDS_PER_BLOCK);
	localparam int NUM_ROUNDS       = 16;

	typedef struct packed {
		logic        mode;
		logic [63:0] ref_lo;
		logic [63:0] ref_hi;
		logic [63:0] next_lo;
		logic [63:0] next_hi;
	} in_t;

	typedef struct packed {
		logic [63:0] out_lo;
		logic [63:0] out_hi;
		logic        out_last;
	} out_t;

	localparam logic MODE_LOAD     = 1'b0;
	localparam logic MODE_COMPRESS = 1'b1;

	typedef enum logic [1:0] {
		ROT32 = 2'd0,
		ROT24 = 2'd1,
		ROT16 = 2'd2,
		ROT63 = 2'd3
	} rot_t;

	// One operation of the shared unit
	typedef struct packed {
		logic        blam;
		rot_t        rot;
		logic [63:0] x;
		logic [63:0] y;
	} alu_op_t;

	// Register-file selection for one step of a mix
	typedef struct packed {
		logic [3:0] dst;
		logic [3:0] src;
		logic       blam;
		rot_t       rot;
	} step_t;

	// Word positions a, b, c, d of each of the eight mixes of a round
	function automatic logic [15:0] mix_abcd(input logic [2:0] m);
		logic [15:0] r;
		case (m)
			3'd0: r = {4'd0, 4'd4, 4'd8,  4'd12};
			3'd1: r = {4'd1, 4'd5, 4'd9,  4'd13};
			3'd2: r = {4'd2, 4'd6, 4'd10, 4'd14};
			3'd3: r = {4'd3, 4'd7, 4'd11, 4'd15};
			3'd4: r = {4'd0, 4'd5, 4'd10, 4'd15};
			3'd5: r = {4'd1, 4'd6, 4'd11, 4'd12};
			3'd6: r = {4'd2, 4'd7, 4'd8,  4'd13};
			3'd7: r = {4'd3, 4'd4, 4'd9,  4'd14};
			default: r = '0;
		endcase
		return r;
	endfunction

	// Destination, source and operation of step k of mix m
	function automatic step_t step_sel(input logic [2:0] m, input logic [2:0] k);
		logic [15:0] q;
		logic [3:0]  a, b, c, d;
		step_t       s;
		q = mix_abcd(m);
		a = q[15:12];
		b = q[11:8];
		c = q[7:4];
		d = q[3:0];
		s.blam = ~k[0];
		s.rot  = ROT32;
		case (k)
			3'd0: begin s.dst = a; s.src = b; end
			3'd1: begin s.dst = d; s.src = a; s.rot = ROT32; end
			3'd2: begin s.dst = c; s.src = d; end
			3'd3: begin s.dst = b; s.src = c; s.rot = ROT24; end
			3'd4: begin s.dst = a; s.src = b; end
			3'd5: begin s.dst = d; s.src = a; s.rot = ROT16; end
			3'd6: begin s.dst = c; s.src = d; end
			3'd7: begin s.dst = b; s.src = c; s.rot = ROT63; end
			default: begin s.dst = a; s.src = b; end
		endcase
		return s;
	endfunction

	// Block word gathered as word j of round r: rows first, then column pairs
	function automatic logic [6:0] word_idx(input logic [3:0] r, input logic [3:0] j);
		logic [6:0] w;
		if (!r[3]) begin
			w = {r[2:0], j};
		end else begin
			w = {j[3:1], r[2:0], j[0]};
		end
		return w;
	endfunction

endpackage

>>> sv/argon2_block_compression_unit.sv
// Top level: sequencer, state and xor-base memories, round register file and output register.
`timescale 1ns / 1ps

// Argon2 compression G over a 1024-byte block streamed as 64 owords. A load transfer
// writes the low and then the high state word, and a compress transfer reads both words
// and writes them back xored with the reference, the input being stalled meanwhile. The
// compress transfer at oword 63 then runs 16 BlaMka rounds on one shared registered
// multiply-add/rotate unit: each round gathers 16 words from the state memory, runs
// 64 unit operations and writes the words back. The 64 result owords follow, each held
// while the output is stalled; input stays stalled until the last one is transferred.
// The state memory is cleared by per-word valid bits at reset.
module argon2_block_compression_unit
	import a2bc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	input  logic in_valid,
	output logic in_stall,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_stall,
	output out_t out_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_LD_LO, S_LD_HI, S_C_RLO, S_C_RHI, S_C_WHI,
		S_GATHER, S_MIX, S_SCATTER, S_O_RLO, S_O_RHI, S_O_WHI, S_O_WAIT
	} state_t;

	state_t              state_q;
	logic                xor_mode_q;
	logic [OW_W-1:0]     count_q;
	logic [OW_W-1:0]     pos_q;
	logic [OW_W-1:0]     oidx_q;
	in_t                 in_q;
	logic [3:0]          rnd_q;
	logic [4:0]          cnt_q;
	logic [2:0]          mix_q;
	logic [2:0]          stp_q;
	logic                ph_q;
	logic                gen_s1;
	logic [3:0]          gtag_s1;
	logic [63:0]         v_q [16];
	out_t                out_q;
	logic                out_valid_q;

	logic [63:0]         st_mem [WORDS_PER_BLOCK];
	logic [63:0]         xb_mem [WORDS_PER_BLOCK];
	logic [WORDS_PER_BLOCK-1:0] st_vld_q;
	logic [63:0]         st_rd_s1;
	logic [63:0]         xb_rd_s1;
	logic                st_rv_s1;

	logic                st_we, xb_we;
	logic [WA_W-1:0]     raddr, st_waddr;
	logic [63:0]         st_wdata, xb_wdata, rd, lo_x;
	step_t               sel;
	alu_op_t             aop;
	logic [63:0]         ares;

	a2bc_alu u_alu (
		.clk (clk),
		.op  (aop),
		.res (ares)
	);

	assign rd        = st_rv_s1 ? st_rd_s1 : 64'd0;
	assign sel       = step_sel(mix_q, stp_q);
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Feed the shared unit from the round register file
	always_comb begin
		aop.blam = sel.blam;
		aop.rot  = sel.rot;
		aop.x    = v_q[sel.dst];
		aop.y    = v_q[sel.src];
	end

	// Drive memory ports from the sequencer state
	always_comb begin
		st_we    = 1'b0;
		xb_we    = 1'b0;
		raddr    = '0;
		st_waddr = '0;
		st_wdata = '0;
		xb_wdata = '0;
		lo_x     = rd ^ in_q.ref_lo;
		case (state_q)
			S_LD_LO: begin
				st_we = 1'b1; st_waddr = {pos_q, 1'b0}; st_wdata = in_q.ref_lo;
			end
			S_LD_HI: begin
				st_we = 1'b1; st_waddr = {pos_q, 1'b1}; st_wdata = in_q.ref_hi;
			end
			S_C_RLO: begin
				raddr = {pos_q, 1'b0};
			end
			S_C_RHI: begin
				raddr    = {pos_q, 1'b1};
				st_we    = 1'b1;
				xb_we    = 1'b1;
				st_waddr = {pos_q, 1'b0};
				st_wdata = lo_x;
				xb_wdata = lo_x ^ (xor_mode_q ? in_q.next_lo : 64'd0);
			end
			S_C_WHI: begin
				st_we    = 1'b1;
				xb_we    = 1'b1;
				st_waddr = {pos_q, 1'b1};
				st_wdata = rd ^ in_q.ref_hi;
				xb_wdata = rd ^ in_q.ref_hi ^ (xor_mode_q ? in_q.next_hi : 64'd0);
			end
			S_GATHER: begin
				raddr = word_idx(rnd_q, cnt_q[3:0]);
			end
			S_SCATTER: begin
				st_we    = 1'b1;
				st_waddr = word_idx(rnd_q, cnt_q[3:0]);
				st_wdata = v_q[cnt_q[3:0]];
			end
			S_O_RLO: begin
				raddr = {oidx_q, 1'b0};
			end
			S_O_RHI: begin
				raddr    = {oidx_q, 1'b1};
				st_we    = 1'b1;
				st_waddr = {oidx_q, 1'b0};
				st_wdata = rd ^ xb_rd_s1;
			end
			S_O_WHI: begin
				st_we    = 1'b1;
				st_waddr = {oidx_q, 1'b1};
				st_wdata = rd ^ xb_rd_s1;
			end
			default: begin
				st_we = 1'b0;
			end
		endcase
	end

	// Memories: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[st_waddr] <= st_wdata;
		end
		if (xb_we) begin
			xb_mem[st_waddr] <= xb_wdata;
		end
		st_rd_s1 <= st_mem[raddr];
		xb_rd_s1 <= xb_mem[raddr];
	end

	// Valid bits: an unwritten state word reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_vld_q <= '0;
			st_rv_s1 <= 1'b0;
		end else begin
			if (st_we) begin
				st_vld_q[st_waddr] <= 1'b1;
			end
			st_rv_s1 <= st_vld_q[raddr];
		end
	end

	// Round register file: gathered words and unit results
	always_ff @(posedge clk) begin
		if (gen_s1) begin
			v_q[gtag_s1] <= rd;
		end else if (state_q == S_MIX && ph_q) begin
			v_q[sel.dst] <= ares;
		end
	end

	// Hold the transfer payload and output words
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_q <= in_data;
		end
		if (state_q == S_O_RHI) begin
			out_q.out_lo <= rd ^ xb_rd_s1;
		end
		if (state_q == S_O_WHI) begin
			out_q.out_hi   <= rd ^ xb_rd_s1;
			out_q.out_last <= (oidx_q == OW_W'(OWORDS_PER_BLOCK - 1));
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			xor_mode_q  <= 1'b0;
			count_q     <= '0;
			pos_q       <= '0;
			oidx_q      <= '0;
			rnd_q       <= '0;
			cnt_q       <= '0;
			mix_q       <= '0;
			stp_q       <= '0;
			ph_q        <= 1'b0;
			gen_s1      <= 1'b0;
			gtag_s1     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				xor_mode_q <= cfg_wdata;
			end
			gen_s1  <= (state_q == S_GATHER) && !cnt_q[4];
			gtag_s1 <= cnt_q[3:0];
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						pos_q   <= count_q;
						count_q <= count_q + 1'b1;
						state_q <= (in_data.mode == MODE_LOAD) ? S_LD_LO : S_C_RLO;
					end
				end
				S_LD_LO: state_q <= S_LD_HI;
				S_LD_HI: state_q <= S_IDLE;
				S_C_RLO: state_q <= S_C_RHI;
				S_C_RHI: state_q <= S_C_WHI;
				S_C_WHI: begin
					if (pos_q == OW_W'(OWORDS_PER_BLOCK - 1)) begin
						rnd_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_GATHER;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_GATHER: begin
					if (cnt_q[4]) begin
						mix_q   <= '0;
						stp_q   <= '0;
						ph_q    <= 1'b0;
						state_q <= S_MIX;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_MIX: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						stp_q <= stp_q + 1'b1;
						if (stp_q == 3'd7) begin
							mix_q <= mix_q + 1'b1;
							if (mix_q == 3'd7) begin
								cnt_q   <= '0;
								state_q <= S_SCATTER;
							end
						end
					end
				end
				S_SCATTER: begin
					if (cnt_q[3:0] == 4'd15) begin
						cnt_q <= '0;
						if (rnd_q == 4'(NUM_ROUNDS - 1)) begin
							oidx_q  <= '0;
							state_q <= S_O_RLO;
						end else begin
							rnd_q   <= rnd_q + 1'b1;
							state_q <= S_GATHER;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_O_RLO: state_q <= S_O_RHI;
				S_O_RHI: state_q <= S_O_WHI;
				S_O_WHI: begin
					out_valid_q <= 1'b1;
					state_q     <= S_O_WAIT;
				end
				S_O_WAIT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						oidx_q      <= oidx_q + 1'b1;
						if (oidx_q == OW_W'(OWORDS_PER_BLOCK - 1)) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_O_RLO;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> sv/a2bc_alu.sv
// Shared BlaMka multiply-add and xor-rotate unit, one register after the multiplier.
`timescale 1ns / 1ps

module a2bc_alu
	import a2bc_pkg::*;
(
	input  logic        clk,
	input  alu_op_t     op,
	output logic [63:0] res
);

	alu_op_t     op_s1;
	logic [63:0] prod_s1;
	logic [63:0] xr;

	// Register operands and the low-half product
	always_ff @(posedge clk) begin
		op_s1   <= op;
		prod_s1 <= 64'(op.x[31:0] * op.y[31:0]);
	end

	// Finish: x + y + 2*prod, or rotate right of x ^ y
	always_comb begin
		xr = op_s1.x ^ op_s1.y;
		if (op_s1.blam) begin
			res = op_s1.x + op_s1.y + {prod_s1[62:0], 1'b0};
		end else begin
			case (op_s1.rot)
				ROT32:   res = {xr[31:0], xr[63:32]};
				ROT24:   res = {xr[23:0], xr[63:24]};
				ROT16:   res = {xr[15:0], xr[63:16]};
				ROT63:   res = {xr[62:0], xr[63]};
				default: res = xr;
			endcase
		end
	end

endmodule

>>> sv/a2bc_checker.sv
// Port-level checker for the Argon2 block compression unit, bound to the top level.
`timescale 1ns / 1ps

module a2bc_checker
	import a2bc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input out_t out_data
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// No input transfer while results are pending
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");

	// Input closes after every transfer
	a_busy_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after transfer");

	// Nothing follows the last oword of a block
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_data.out_last |=> !out_valid)
		else $error("result after last oword");

endmodule

bind argon2_block_compression_unit a2bc_checker u_a2bc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

>>> tb/tb_argon2_block_compression_unit.sv
// Self-checking testbench for the Argon2 block compression unit: directed and random owords.
`timescale 1ns / 1ps

module tb_argon2_block_compression_unit;
	import a2bc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t  in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;

	argon2_block_compression_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	always #1 clk = ~clk;

	// Timeout guard
	initial begin
		#1_000_000;
		$display("Timeout waiting for the block");
		$display("Some tests failed");
		$finish;
	end

	// Shadow of the block: state words, xor base, oword position and mode
	logic [63:0] shadow_state [WORDS_PER_BLOCK];
	logic [63:0] shadow_base  [WORDS_PER_BLOCK];
	logic [63:0] mixv [16];
	int          shadow_pos;
	logic        shadow_xor;
	out_t        expected_owords [$];

	int mismatches = 0;
	int owords_seen = 0;
	int items_sent = 0;
	int loads_sent = 0;
	int blocks_done = 0;
	int holdoff_cycles = 0;
	bit holdoff_done = 1'b0;

	function automatic logic [63:0] rotr(input logic [63:0] v, input int n);
		return (v >> n) | (v << (64 - n));
	endfunction

	function automatic logic [63:0] mul_add(input logic [63:0] x, input logic [63:0] y);
		logic [63:0] p;
		p = 64'(x[31:0]) * 64'(y[31:0]);
		return x + y + (p << 1);
	endfunction

	task automatic quarter(input int a, input int b, input int c, input int d);
		mixv[a] = mul_add(mixv[a], mixv[b]);
		mixv[d] = rotr(mixv[d] ^ mixv[a], 32);
		mixv[c] = mul_add(mixv[c], mixv[d]);
		mixv[b] = rotr(mixv[b] ^ mixv[c], 24);
		mixv[a] = mul_add(mixv[a], mixv[b]);
		mixv[d] = rotr(mixv[d] ^ mixv[a], 16);
		mixv[c] = mul_add(mixv[c], mixv[d]);
		mixv[b] = rotr(mixv[b] ^ mixv[c], 63);
	endtask

	// One round over 16 words; rows for r < 8, column pairs after
	task automatic round_words(input int r);
		int idx [16];
		for (int j = 0; j < 16; j++)
			idx[j] = (r < 8) ? 16 * r + j : 2 * (r - 8) + 16 * (j / 2) + (j % 2);
		for (int j = 0; j < 16; j++)
			mixv[j] = shadow_state[idx[j]];
		quarter(0, 4, 8, 12);
		quarter(1, 5, 9, 13);
		quarter(2, 6, 10, 14);
		quarter(3, 7, 11, 15);
		quarter(0, 5, 10, 15);
		quarter(1, 6, 11, 12);
		quarter(2, 7, 8, 13);
		quarter(3, 4, 9, 14);
		for (int j = 0; j < 16; j++)
			shadow_state[idx[j]] = mixv[j];
	endtask

	// Advance the shadow by one accepted oword and queue any new block
	task automatic compress_oword(input in_t it);
		int   lo;
		out_t o;
		lo = 2 * shadow_pos;
		if (it.mode == MODE_LOAD) begin
			shadow_state[lo] = it.ref_lo;
			shadow_state[lo + 1] = it.ref_hi;
		end else begin
			shadow_state[lo] ^= it.ref_lo;
			shadow_state[lo + 1] ^= it.ref_hi;
			shadow_base[lo] = shadow_state[lo] ^ (shadow_xor ? it.next_lo : 64'd0);
			shadow_base[lo + 1] = shadow_state[lo + 1] ^ (shadow_xor ? it.next_hi : 64'd0);
			if (shadow_pos == OWORDS_PER_BLOCK - 1) begin
				for (int r = 0; r < NUM_ROUNDS; r++)
					round_words(r);
				for (int i = 0; i < OWORDS_PER_BLOCK; i++) begin
					shadow_state[2 * i] ^= shadow_base[2 * i];
					shadow_state[2 * i + 1] ^= shadow_base[2 * i + 1];
					o.out_lo = shadow_state[2 * i];
					o.out_hi = shadow_state[2 * i + 1];
					o.out_last = (i == OWORDS_PER_BLOCK - 1);
					expected_owords.push_back(o);
				end
				blocks_done++;
			end
		end
		shadow_pos = (shadow_pos + 1) % OWORDS_PER_BLOCK;
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("Mismatch at oword %0d: %s got %h expected %h", owords_seen, what, got, want);
		mismatches++;
	endtask

	// Check each output transfer against the oldest expected oword
	always @(posedge clk) begin
		out_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_owords.size() == 0) begin
				report_mismatch("unexpected oword", out_data.out_lo, 64'd0);
			end else begin
				w = expected_owords.pop_front();
				if (out_data.out_lo !== w.out_lo)
					report_mismatch("out_lo", out_data.out_lo, w.out_lo);
				if (out_data.out_hi !== w.out_hi)
					report_mismatch("out_hi", out_data.out_hi, w.out_hi);
				if (out_data.out_last !== w.out_last)
					report_mismatch("out_last", 64'(out_data.out_last), 64'(w.out_last));
			end
			owords_seen++;
			if (owords_seen == 100 && !holdoff_done) begin
				holdoff_cycles = 600;
				holdoff_done = 1'b1;
			end
		end
	end

	// Output stall: runs of flow and stall, rare long stalls, one long hold-off
	initial begin
		int run_left;
		bit stalling;
		run_left = 0;
		stalling = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_cycles > 0) begin
				holdoff_cycles--;
				out_stall = 1'b1;
			end else begin
				if (run_left == 0) begin
					stalling = ($urandom_range(0, 99) < 30);
					if (!stalling)
						run_left = $urandom_range(1, 20);
					else if ($urandom_range(0, 19) == 0)
						run_left = $urandom_range(15, 60);
					else
						run_left = $urandom_range(1, 4);
				end
				run_left--;
				out_stall = stalling;
			end
		end
	end

	// Offer one oword and hold it until it is transferred
	task automatic send_oword(input in_t it);
		@(negedge clk);
		in_data = it;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		compress_oword(it);
		items_sent++;
		if (it.mode == MODE_LOAD)
			loads_sent++;
	endtask

	task automatic idle_gap(input bit calm);
		int g;
		g = 0;
		if (!calm) begin
			case ($urandom_range(0, 9))
				0, 1, 2: g = $urandom_range(1, 3);
				3: g = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : 0;
				default: g = 0;
			endcase
		end
		repeat (g) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
	endtask

	// Quiet the input, drain the block, then write the mode register
	task automatic set_xor_mode(input logic v);
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_owords.size() != 0)
			@(posedge clk);
		repeat (20) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		shadow_xor = v;
	endtask

	function automatic logic [63:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 64'd0;
			1: return '1;
			2: return 64'd1 << $urandom_range(0, 63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic in_t random_oword(input logic md);
		in_t t;
		t.mode = md;
		t.ref_lo = pick_word();
		t.ref_hi = pick_word();
		t.next_lo = pick_word();
		t.next_hi = pick_word();
		return t;
	endfunction

	in_t corner_rows [25];

	initial begin
		logic md;
		int  kind;
		bit  calm;
		for (int i = 0; i < WORDS_PER_BLOCK; i++) begin
			shadow_state[i] = 64'd0;
			shadow_base[i] = 64'd0;
		end
		shadow_pos = 0;
		shadow_xor = 1'b0;

		// Corner owords: extremes, walking bits and alternating patterns
		corner_rows[0] = '{MODE_COMPRESS, 64'd0, 64'd0, 64'd0, 64'd0};
		corner_rows[1] = '{MODE_COMPRESS, '1, '1, '1, '1};
		corner_rows[2] = '{MODE_COMPRESS, '1, 64'd0, 64'd0, '1};
		corner_rows[3] = '{MODE_COMPRESS, 64'd0, '1, '1, 64'd0};
		corner_rows[4] = '{MODE_COMPRESS, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
			64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};
		corner_rows[5] = '{MODE_COMPRESS, 64'h8000_0000_0000_0000, 64'd1,
			64'd1, 64'h8000_0000_0000_0000};
		corner_rows[6] = '{MODE_COMPRESS, 64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
			64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF};
		for (int i = 7; i < 25; i++)
			corner_rows[i] = '{MODE_COMPRESS, 64'd1 << (i * 3), ~(64'd1 << (i * 3 + 1)),
				64'd1 << (63 - i), {$urandom, $urandom}};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		set_xor_mode(1'b0);

		// First block: compress only, so every xor-base entry gets written
		foreach (corner_rows[i])
			send_oword(corner_rows[i]);
		while (shadow_pos != 0) begin
			send_oword(random_oword(MODE_COMPRESS));
			idle_gap(1'b0);
		end

		// Further blocks, the mode register changed between them
		for (int b = 1; b < 6; b++) begin
			set_xor_mode((b < 4) ? logic'(b % 2) : logic'($urandom_range(0, 1)));
			kind = (b == 5) ? 2 : $urandom_range(0, 2);
			calm = (b == 2);
			for (int p = 0; p < OWORDS_PER_BLOCK; p++) begin
				case (kind)
					0: md = MODE_COMPRESS;
					1: md = (p < 16) ? MODE_LOAD : MODE_COMPRESS;
					default: md = logic'($urandom_range(0, 1));
				endcase
				// A random block may end on a load and produce nothing
				if (p == OWORDS_PER_BLOCK - 1 && kind != 2)
					md = MODE_COMPRESS;
				send_oword(random_oword(md));
				idle_gap(calm);
			end
		end
		if (loads_sent == 0) begin
			send_oword(random_oword(MODE_LOAD));
		end

		// Drain and let the block settle
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_owords.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("Sent %0d owords (%0d loads), %0d blocks compressed, %0d owords checked",
			items_sent, loads_sent, blocks_done, owords_seen);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

>>> argon2_block_compression_unit.f
sv/a2bc_pkg.sv
sv/a2bc_alu.sv
sv/argon2_block_compression_unit.sv
sv/a2bc_checker.sv
tb/tb_argon2_block_compression_unit.sv
